>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset.
`define FCL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked in every cycle, reset included.
`define FCL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCL_ASSERT(lbl, clk, rst, prop, msg)
`define FCL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hdl/fcl_pkg.sv
// Package: types, constants and helpers of the fault code LED driver.
`timescale 1ns / 1ps

package fcl_pkg;

   localparam int MAX_SLOTS       = 8;
   localparam int FAULT_SLOTS_DEF = 8;
   localparam int CSR_IDX_W       = 3;
   localparam int REG_W           = 16;

   localparam logic [REG_W-1:0] FULL_DUTY_RST     = 16'd1000;
   localparam logic [REG_W-1:0] ELEM_BLINK_RST    = 16'd2000;
   localparam logic [REG_W-1:0] BREATH_STEP_RST   = 16'd10;
   localparam logic [REG_W-1:0] BREATH_INC_RST    = 16'd10;
   localparam logic [REG_W-1:0] FLASH_RST         = 16'd150;
   localparam logic [REG_W-1:0] DIGIT_GAP_RST     = 16'd500;
   localparam logic [REG_W-1:0] REPEAT_PAUSE_RST  = 16'd2000;
   localparam logic [REG_W-1:0] FAULT_WAIT_RST    = 16'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULL_DUTY    = 3'd0,
      CSR_ELEM_BLINK   = 3'd1,
      CSR_BREATH_STEP  = 3'd2,
      CSR_BREATH_INC   = 3'd3,
      CSR_FLASH        = 3'd4,
      CSR_DIGIT_GAP    = 3'd5,
      CSR_REPEAT_PAUSE = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      DIG_HUNDREDS = 2'd0,
      DIG_TENS     = 2'd1,
      DIG_UNITS    = 2'd2,
      DIG_NONE     = 2'd3
   } digit_pos_type;

   typedef struct packed {
      logic [REG_W-1:0] full_duty;
      logic [REG_W-1:0] element_blink_ms;
      logic [REG_W-1:0] breath_step_ms;
      logic [REG_W-1:0] breath_increment;
      logic [REG_W-1:0] flash_ms;
      logic [REG_W-1:0] digit_gap_ms;
      logic [REG_W-1:0] repeat_pause_ms;
   } cfg_type;

   typedef struct packed {
      logic        written;
      logic [15:0] duty;
   } wr_word_type;

   // Decimal digit of an 8-bit code; tens by reciprocal multiply, exact for rem up to 99.
   function automatic logic [3:0] dec_digit(input logic [7:0] code, input logic [1:0] pos);
      logic [1:0]  hund;
      logic [6:0]  rem;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  units;
      logic [3:0]  res;
      hund  = (code >= 8'd200) ? 2'd2 : ((code >= 8'd100) ? 2'd1 : 2'd0);
      rem   = 7'(code - 8'(hund) * 8'd100);
      prod  = 15'(rem) * 15'd205;
      tens  = prod[14:11];
      units = 7'(rem - 7'(tens) * 7'd10);
      case (digit_pos_type'(pos))
         DIG_HUNDREDS: res = {2'b00, hund};
         DIG_TENS:     res = tens;
         DIG_UNITS:    res = units[3:0];
         default:      res = 4'd0;
      endcase
      return res;
   endfunction

endpackage

>>> hdl/fcl_ifaces.sv
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps

interface fcl_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        burner_on;
   logic        element_on;
   logic [7:0]  fault_0;
   logic [7:0]  fault_1;
   logic [7:0]  fault_2;
   logic [7:0]  fault_3;
   logic [7:0]  fault_4;
   logic [7:0]  fault_5;
   logic [7:0]  fault_6;
   logic [7:0]  fault_7;

   modport source (output valid, now_ms, burner_on, element_on, fault_0, fault_1, fault_2,
                   fault_3, fault_4, fault_5, fault_6, fault_7, input ready);
   modport sink   (input valid, now_ms, burner_on, element_on, fault_0, fault_1, fault_2,
                   fault_3, fault_4, fault_5, fault_6, fault_7, output ready);
endinterface

interface fcl_rsp_if;
   logic        valid;
   logic        ready;
   logic        duty_written;
   logic [15:0] duty;

   modport source (output valid, duty_written, duty, input ready);
   modport sink   (input valid, duty_written, duty, output ready);
endinterface

>>> hdl/fcl_fault_seq.sv
// Fault code blink sequencer: digit position, flash count and pause timing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcl_fault_seq import fcl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  logic [31:0] now_ms,
   input  logic [7:0]  code,
   input  cfg_type     cfg,
   output wr_word_type wr
);

   logic [31:0] fault_timer_ff, fault_timer_in;
   logic [15:0] fault_wait_ff,  fault_wait_in;
   logic [1:0]  digit_index_ff, digit_index_in;
   logic [4:0]  flash_step_ff,  flash_step_in;
   logic        pause_pend_ff,  pause_pend_in;

   logic [31:0] elapsed;
   logic        expired;
   logic [1:0]  di;
   logic [4:0]  fs;
   logic [3:0]  n;
   logic [1:0]  di_next;

   always_comb begin
      elapsed = now_ms - fault_timer_ff;
      expired = (elapsed >= {16'd0, fault_wait_ff});
      di      = pause_pend_ff ? 2'd0 : digit_index_ff;
      fs      = pause_pend_ff ? 5'd0 : flash_step_ff;
      n       = dec_digit(code, di);
      di_next = di + 2'd1;

      fault_timer_in = fault_timer_ff;
      fault_wait_in  = fault_wait_ff;
      digit_index_in = digit_index_ff;
      flash_step_in  = flash_step_ff;
      pause_pend_in  = pause_pend_ff;
      wr             = '0;

      if (expired) begin
         fault_timer_in = now_ms;
         pause_pend_in  = 1'b0;
         wr.written     = 1'b1;
         if (fs < {n, 1'b0}) begin
            wr.duty        = fs[0] ? 16'd0 : cfg.full_duty;
            flash_step_in  = fs + 5'd1;
            digit_index_in = di;
            fault_wait_in  = cfg.flash_ms;
         end else begin
            digit_index_in = di_next;
            flash_step_in  = 5'd0;
            if (digit_pos_type'(di_next) == DIG_NONE) begin
               pause_pend_in = 1'b1;
               fault_wait_in = cfg.repeat_pause_ms;
            end else begin
               fault_wait_in = cfg.digit_gap_ms;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_timer_ff <= '0;
         fault_wait_ff  <= FAULT_WAIT_RST;
         digit_index_ff <= '0;
         flash_step_ff  <= '0;
         pause_pend_ff  <= 1'b0;
      end else if (step_en) begin
         fault_timer_ff <= fault_timer_in;
         fault_wait_ff  <= fault_wait_in;
         digit_index_ff <= digit_index_in;
         flash_step_ff  <= flash_step_in;
         pause_pend_ff  <= pause_pend_in;
      end
   end

   // a digit is at most 9, so a flash count never passes 18
   `FCL_ASSERT(a_flash_bound, clock, reset, flash_step_ff <= 5'd18, "flash step out of range")
   `FCL_ASSERT(a_pause_pos, clock, reset, pause_pend_ff |-> digit_index_ff == 2'd3, "pause without last digit")
   `FCL_ASSERT(a_pause_step, clock, reset, pause_pend_ff |-> flash_step_ff == 5'd0, "pause with open flash")

endmodule

>>> hdl/fault_code_led_pattern_driver_core.sv
// Top level of the fault code LED pattern driver.
//
//  channel  dir  handshake              word
//  req_ch   in   valid/ready            now_ms, burner_on, element_on, fault_0..fault_7
//  rsp_ch   out  valid/ready            duty_written, duty
//  csr_*    in   csr_we (no back-press) csr_index, csr_wdata
//
// Two register stages: a request register, then the result register. All the
// work of one word sits between them, so one word per cycle is sustained while
// the response is not stalled, and each word sees the state left by the word
// before it. An accepted word is loaded into the request register, then into
// the result register, whose valid flag drives rsp_ch.valid.
// A stalled response holds the result register; the request register still
// fills, so one more word is taken before req_ch.ready drops.
// Synchronous reset clears the valid flags, mode and fault state; CSRs get reset values.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fault_code_led_pattern_driver_core import fcl_pkg::*; #(
   parameter int FAULT_SLOTS = FAULT_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   fcl_req_if.sink              req_ch,
   fcl_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   // ---- configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_duty        <= FULL_DUTY_RST;
         cfg_ff.element_blink_ms <= ELEM_BLINK_RST;
         cfg_ff.breath_step_ms   <= BREATH_STEP_RST;
         cfg_ff.breath_increment <= BREATH_INC_RST;
         cfg_ff.flash_ms         <= FLASH_RST;
         cfg_ff.digit_gap_ms     <= DIGIT_GAP_RST;
         cfg_ff.repeat_pause_ms  <= REPEAT_PAUSE_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FULL_DUTY:    cfg_ff.full_duty        <= csr_wdata;
            CSR_ELEM_BLINK:   cfg_ff.element_blink_ms <= csr_wdata;
            CSR_BREATH_STEP:  cfg_ff.breath_step_ms   <= csr_wdata;
            CSR_BREATH_INC:   cfg_ff.breath_increment <= csr_wdata;
            CSR_FLASH:        cfg_ff.flash_ms         <= csr_wdata;
            CSR_DIGIT_GAP:    cfg_ff.digit_gap_ms     <= csr_wdata;
            CSR_REPEAT_PAUSE: cfg_ff.repeat_pause_ms  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- request register
   logic                      s1_valid_ff;
   logic [31:0]               now_ff;
   logic                      burner_ff;
   logic                      element_ff;
   logic [MAX_SLOTS-1:0][7:0] fault_ff;

   logic        out_valid_ff;
   wr_word_type out_ff;
   logic        advance;

   // the request word moves on when the result register is free or draining
   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         now_ff      <= req_ch.now_ms;
         burner_ff   <= req_ch.burner_on;
         element_ff  <= req_ch.element_on;
         fault_ff[0] <= req_ch.fault_0;
         fault_ff[1] <= req_ch.fault_1;
         fault_ff[2] <= req_ch.fault_2;
         fault_ff[3] <= req_ch.fault_3;
         fault_ff[4] <= req_ch.fault_4;
         fault_ff[5] <= req_ch.fault_5;
         fault_ff[6] <= req_ch.fault_6;
         fault_ff[7] <= req_ch.fault_7;
      end
   end

   // ---- first nonzero fault among the watched slots, lowest slot wins
   logic [7:0] code;
   logic       fault_act;

   always_comb begin
      code = 8'd0;
      for (int i = FAULT_SLOTS - 1; i >= 0; i--) begin
         if (fault_ff[i] != 8'd0) begin
            code = fault_ff[i];
         end
      end
      fault_act = (code != 8'd0);
   end

   wr_word_type fault_wr;

   fcl_fault_seq u_fault_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance && fault_act),
      .now_ms  (now_ff),
      .code    (code),
      .cfg     (cfg_ff),
      .wr      (fault_wr)
   );

   // ---- button modes: steady, element blink, burner breathing
   logic [31:0] mode_timer_ff, mode_timer_in;
   logic        blink_on_ff,   blink_on_in;
   logic [16:0] breath_lvl_ff, breath_lvl_in;
   logic        breath_fall_ff, breath_fall_in;

   logic [31:0]        mode_elapsed;
   logic signed [18:0] lvl;
   logic signed [18:0] full_s;
   logic [16:0]        raw_duty;
   wr_word_type        btn_wr;

   always_comb begin
      mode_elapsed   = now_ff - mode_timer_ff;
      full_s         = signed'({3'b000, cfg_ff.full_duty});
      lvl            = signed'({2'b00, breath_lvl_ff});
      mode_timer_in  = mode_timer_ff;
      blink_on_in    = blink_on_ff;
      breath_lvl_in  = breath_lvl_ff;
      breath_fall_in = breath_fall_ff;
      raw_duty       = 17'd0;
      btn_wr         = '0;

      if (burner_ff && element_ff) begin
         btn_wr.written = 1'b1;
         raw_duty       = {1'b0, cfg_ff.full_duty};
         blink_on_in    = 1'b0;
         breath_lvl_in  = '0;
         breath_fall_in = 1'b0;
      end else if (element_ff) begin
         if (mode_elapsed >= {16'd0, cfg_ff.element_blink_ms}) begin
            mode_timer_in  = now_ff;
            blink_on_in    = !blink_on_ff;
            btn_wr.written = 1'b1;
            raw_duty       = blink_on_ff ? 17'd0 : {1'b0, cfg_ff.full_duty};
         end
         breath_lvl_in  = '0;
         breath_fall_in = 1'b0;
      end else if (burner_ff) begin
         if (mode_elapsed >= {16'd0, cfg_ff.breath_step_ms}) begin
            mode_timer_in  = now_ff;
            breath_fall_in = breath_fall_ff;
            if (breath_fall_ff) begin
               lvl = lvl - signed'({3'b000, cfg_ff.breath_increment});
            end else begin
               lvl = lvl + signed'({3'b000, cfg_ff.breath_increment});
            end
            // top clamp turns the ramp; bottom clamp turns it back up
            if (lvl >= full_s) begin
               lvl            = full_s;
               breath_fall_in = 1'b1;
            end
            if (lvl <= 19'sd0) begin
               lvl            = 19'sd0;
               breath_fall_in = 1'b0;
            end
            breath_lvl_in  = lvl[16:0];
            btn_wr.written = 1'b1;
            raw_duty       = lvl[16:0];
         end
         blink_on_in = 1'b0;
      end else begin
         btn_wr.written = 1'b1;
         blink_on_in    = 1'b0;
         breath_lvl_in  = '0;
         breath_fall_in = 1'b0;
      end

      if (raw_duty > {1'b0, cfg_ff.full_duty}) begin
         btn_wr.duty = cfg_ff.full_duty;
      end else begin
         btn_wr.duty = raw_duty[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_timer_ff  <= '0;
         blink_on_ff    <= 1'b0;
         breath_lvl_ff  <= '0;
         breath_fall_ff <= 1'b0;
      end else if (advance && !fault_act) begin
         mode_timer_ff  <= mode_timer_in;
         blink_on_ff    <= blink_on_in;
         breath_lvl_ff  <= breath_lvl_in;
         breath_fall_ff <= breath_fall_in;
      end
   end

   // ---- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= fault_act ? fault_wr : btn_wr;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.duty_written = out_ff.written;
   assign rsp_ch.duty         = out_ff.written ? out_ff.duty : 16'd0;

   `FCL_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !s1_valid_ff && !out_valid_ff, "pipe not empty after reset")
   `FCL_ASSERT(a_s1_hold, clock, reset, s1_valid_ff && !advance |=> s1_valid_ff, "request word lost")
   `FCL_ASSERT(a_breath_dir, clock, reset, !(breath_lvl_ff == 17'd0 && breath_fall_ff), "falling at zero level")
   `FCL_ASSERT(a_no_write_zero, clock, reset, rsp_ch.valid && !rsp_ch.duty_written |-> rsp_ch.duty == 16'd0, "duty without write")

endmodule

>>> test/fault_code_led_pattern_driver_core_tb.sv
// Self-checking testbench for the fault code LED pattern driver core.
`timescale 1ns / 1ps

module fault_code_led_pattern_driver_core_tb;
   import fcl_pkg::*;

   localparam int CLK_HALF    = 5;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 60;      // long response stall for the back-pressure test
   localparam int MAX_REPORTS = 200;
   localparam int NUM_REGS    = int'(CSR_REPEAT_PAUSE) + 1;

   typedef logic [REG_W-1:0] reg_set_type [NUM_REGS];

   // One handler call as carried by a request word.
   typedef struct packed {
      logic [31:0]                now_ms;
      logic                       burner_on;
      logic                       element_on;
      logic [MAX_SLOTS-1:0][7:0]  fault;
   } led_call_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fcl_req_if req_if ();
   fcl_rsp_if rsp_if ();

   logic                 csr_we    = 1'b0;
   csr_index_type        csr_index = CSR_FULL_DUTY;
   logic [REG_W-1:0]     csr_wdata = '0;

   always #CLK_HALF clock = ~clock;

   fault_code_led_pattern_driver_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the block: registers plus mode and fault-blink state.
   // ---------------------------------------------------------------------
   reg_set_type led_regs;
   logic [31:0] mode_timer_q     = '0;
   bit          blink_on_q       = 1'b0;
   logic [16:0] breath_level_q   = '0;
   bit          breath_falling_q = 1'b0;
   logic [31:0] fault_timer_q    = '0;
   logic [15:0] fault_wait_q     = FAULT_WAIT_RST;
   digit_pos_type digit_pos_q    = DIG_HUNDREDS;
   logic [4:0]  flash_step_q     = '0;
   bit          pause_pending_q  = 1'b0;

   wr_word_type expected_writes[$];   // duty writes still owed by the block
   logic [31:0] tick_now;             // running millisecond tick for the stimulus
   int          errors      = 0;
   int          cycle_count = 0;
   bit          req_idle_en = 1'b0;
   bit          rsp_idle_en = 1'b0;
   bit          hold_rsp    = 1'b0;

   // A PWM write, clamped to full duty.
   function automatic wr_word_type duty_write(input logic [31:0] level);
      wr_word_type w;
      w.written = 1'b1;
      w.duty = (level > 32'(led_regs[CSR_FULL_DUTY])) ? led_regs[CSR_FULL_DUTY] : level[15:0];
      return w;
   endfunction

   // One step of the fault blink sequencer for the code in force.
   function automatic wr_word_type fault_blink_write(input logic [31:0] now,
                                                     input logic [7:0] code);
      wr_word_type w;
      logic [31:0] elapsed;
      int          digit;
      w = '0;
      elapsed = now - fault_timer_q;
      if (elapsed < 32'(fault_wait_q)) return w;   // still waiting: no write
      fault_timer_q = now;
      if (pause_pending_q) begin
         pause_pending_q = 1'b0;
         digit_pos_q = DIG_HUNDREDS;
         flash_step_q = '0;
      end
      case (digit_pos_q)
         DIG_HUNDREDS: digit = int'(code) / 100;
         DIG_TENS:     digit = (int'(code) / 10) % 10;
         DIG_UNITS:    digit = int'(code) % 10;
         default:      digit = 0;
      endcase
      if (int'(flash_step_q) < 2 * digit) begin
         // even steps light the LED, odd steps turn it off
         w = duty_write(flash_step_q[0] ? 32'd0 : 32'(led_regs[CSR_FULL_DUTY]));
         flash_step_q = flash_step_q + 5'd1;
         fault_wait_q = led_regs[CSR_FLASH];
      end else begin
         // digit done (also when a new code left the step past its end)
         w = duty_write(32'd0);
         digit_pos_q = digit_pos_type'(digit_pos_q + 2'd1);
         flash_step_q = '0;
         if (digit_pos_q == DIG_NONE) begin
            pause_pending_q = 1'b1;
            fault_wait_q = led_regs[CSR_REPEAT_PAUSE];
         end else begin
            fault_wait_q = led_regs[CSR_DIGIT_GAP];
         end
      end
      return w;
   endfunction

   // Expected response word for one accepted request word.
   function automatic wr_word_type predict_led_write(input led_call_type c);
      wr_word_type w;
      logic [7:0]  code;
      logic [31:0] elapsed;
      int          lvl;
      w = '0;
      code = '0;
      for (int i = FAULT_SLOTS_DEF - 1; i >= 0; i--)
         if (c.fault[i] != 8'd0) code = c.fault[i];
      if (code != 8'd0) return fault_blink_write(c.now_ms, code);

      elapsed = c.now_ms - mode_timer_q;
      if (c.burner_on && c.element_on) begin
         w = duty_write(32'(led_regs[CSR_FULL_DUTY]));
         blink_on_q = 1'b0;
         breath_level_q = '0;
         breath_falling_q = 1'b0;
      end else if (c.element_on) begin
         if (elapsed >= 32'(led_regs[CSR_ELEM_BLINK])) begin
            mode_timer_q = c.now_ms;
            blink_on_q = !blink_on_q;
            w = duty_write(blink_on_q ? 32'(led_regs[CSR_FULL_DUTY]) : 32'd0);
         end
         breath_level_q = '0;
         breath_falling_q = 1'b0;
      end else if (c.burner_on) begin
         if (elapsed >= 32'(led_regs[CSR_BREATH_STEP])) begin
            mode_timer_q = c.now_ms;
            lvl = int'(breath_level_q);
            if (breath_falling_q) lvl = lvl - int'(led_regs[CSR_BREATH_INC]);
            else lvl = lvl + int'(led_regs[CSR_BREATH_INC]);
            // top clamp also catches a level left above a lowered full duty
            if (lvl >= int'(led_regs[CSR_FULL_DUTY])) begin
               lvl = int'(led_regs[CSR_FULL_DUTY]);
               breath_falling_q = 1'b1;
            end
            if (lvl <= 0) begin
               lvl = 0;
               breath_falling_q = 1'b0;
            end
            breath_level_q = 17'(lvl);
            w = duty_write(32'(breath_level_q));
         end
         blink_on_q = 1'b0;
      end else begin
         w = duty_write(32'd0);
         blink_on_q = 1'b0;
         breath_level_q = '0;
         breath_falling_q = 1'b0;
      end
      return w;
   endfunction

   // Timing register value: mostly short so that whole sequences play out.
   function automatic logic [15:0] pick_span();
      case ($urandom_range(0, 19))
         0:       return 16'd1;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(9, 400));
         default: return 16'($urandom_range(1, 8));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side. valid stays high across back-to-back words; it only
   // drops for an idle burst or when a phase drains.
   // ---------------------------------------------------------------------
   task automatic send_call(input led_call_type c);
      int gap;
      if (req_idle_en && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.now_ms     <= c.now_ms;
      req_if.burner_on  <= c.burner_on;
      req_if.element_on <= c.element_on;
      req_if.fault_0    <= c.fault[0];
      req_if.fault_1    <= c.fault[1];
      req_if.fault_2    <= c.fault[2];
      req_if.fault_3    <= c.fault[3];
      req_if.fault_4    <= c.fault[4];
      req_if.fault_5    <= c.fault[5];
      req_if.fault_6    <= c.fault[6];
      req_if.fault_7    <= c.fault[7];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_writes.push_back(predict_led_write(c));
   endtask

   // Word with a given mode; code sits in slot, lower slots are clear and
   // higher slots carry random codes that must be ignored.
   task automatic send_mode(input logic [31:0] now, input bit burner, input bit element,
                            input logic [7:0] code, input int slot);
      led_call_type c;
      c.now_ms = now;
      c.burner_on = burner;
      c.element_on = element;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (code == 8'd0 || i < slot) c.fault[i] = 8'd0;
         else if (i == slot) c.fault[i] = code;
         else c.fault[i] = 8'($urandom_range(0, 255));
      end
      send_call(c);
   endtask

   task automatic wait_writes_drained();
      req_if.valid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write every register, back to back; only called with the block idle.
   task automatic load_settings(input reg_set_type vals);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         led_regs[i] = vals[i];
      end
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset settings: every mode, tick wrap, fault timing and code change.
   task automatic test_directed();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      send_mode(32'h0000_0000, 1'b0, 1'b0, 8'd0, 0);   // neither button: zero duty
      send_mode(32'h0000_0005, 1'b1, 1'b1, 8'd0, 0);   // both: full duty
      send_mode(32'hFFFF_FFFF, 1'b0, 1'b1, 8'd0, 0);   // element: toggles on
      send_mode(32'h0000_0100, 1'b0, 1'b1, 8'd0, 0);   // wrapped difference below period
      send_mode(32'h0000_07D0, 1'b0, 1'b1, 8'd0, 0);   // period passed: toggles off
      send_mode(32'h0000_07DA, 1'b1, 1'b0, 8'd0, 0);   // burner: first breath step
      send_mode(32'h0000_07DF, 1'b1, 1'b0, 8'd0, 0);   // step not due yet
      send_mode(32'h0000_0000, 1'b0, 1'b0, 8'd1, 7);   // fault in last slot, timer not expired
      send_mode(32'h0000_000A, 1'b0, 1'b0, 8'd255, 0); // max code: first flash
      send_mode(32'h0000_0064, 1'b0, 1'b0, 8'd255, 0); // mid flash: no write
      send_mode(32'h0000_00A0, 1'b0, 1'b0, 8'd5, 0);   // code change: hundreds digit ends
      send_mode(32'h0000_0294, 1'b0, 1'b0, 8'd5, 0);   // zero tens digit: gap only
      wait_writes_drained();
   endtask

   // Zero full duty, zero timing and a level left above a lowered full duty.
   task automatic test_corner_settings();
      reg_set_type vals;
      vals = led_regs;
      vals[CSR_FULL_DUTY] = 16'd0;
      load_settings(vals);
      send_mode(32'd3000, 1'b1, 1'b0, 8'd0, 0);         // breathing pinned at zero
      send_mode(32'd3000, 1'b1, 1'b1, 8'd0, 0);         // full duty of zero
      wait_writes_drained();

      vals[CSR_FULL_DUTY]    = 16'd1000;
      vals[CSR_ELEM_BLINK]   = 16'd0;
      vals[CSR_BREATH_STEP]  = 16'd0;
      vals[CSR_FLASH]        = 16'd0;
      vals[CSR_DIGIT_GAP]    = 16'd0;
      vals[CSR_REPEAT_PAUSE] = 16'd0;
      load_settings(vals);
      send_mode(32'd3000, 1'b0, 1'b1, 8'd0, 0);         // zero period: toggles every call
      send_mode(32'd3000, 1'b0, 1'b1, 8'd0, 0);
      send_mode(32'd3000, 1'b0, 1'b0, 8'd7, 3);         // zero waits: flash every call
      send_mode(32'd3000, 1'b0, 1'b0, 8'd7, 3);
      wait_writes_drained();

      vals[CSR_ELEM_BLINK]   = 16'd1;
      vals[CSR_BREATH_STEP]  = 16'd1;
      vals[CSR_BREATH_INC]   = 16'd400;
      vals[CSR_FLASH]        = 16'd1;
      vals[CSR_DIGIT_GAP]    = 16'd1;
      vals[CSR_REPEAT_PAUSE] = 16'd1;
      load_settings(vals);
      send_mode(32'd3001, 1'b1, 1'b0, 8'd0, 0);         // level 400
      send_mode(32'd3002, 1'b1, 1'b0, 8'd0, 0);         // level 800
      wait_writes_drained();
      vals[CSR_FULL_DUTY] = 16'd300;
      load_settings(vals);
      send_mode(32'd3003, 1'b1, 1'b0, 8'd0, 0);         // clamps to 300, turns to falling
      send_mode(32'd3004, 1'b1, 1'b0, 8'd0, 0);         // falls through zero
      wait_writes_drained();
   endtask

   // Sessions of one setting each: a running tick with a mode that mostly
   // holds, so blink codes and breathing run through; some noise words.
   task automatic test_random_sessions(input int n_items, input bit with_idle);
      reg_set_type  vals;
      int           sent;
      int           len;
      int           step_max;
      int           slot;
      int           kind;
      bit           burner;
      bit           element;
      logic [7:0]   code;
      led_call_type c;
      sent = 0;
      burner = 1'b0;
      element = 1'b0;
      code = '0;
      slot = 0;
      req_idle_en = with_idle;
      rsp_idle_en = with_idle;
      while (sent < n_items) begin
         wait_writes_drained();
         case ($urandom_range(0, 5))
            0:       vals[CSR_FULL_DUTY] = 16'd1;
            1:       vals[CSR_FULL_DUTY] = 16'hFFFF;
            2:       vals[CSR_FULL_DUTY] = 16'($urandom_range(1, 65535));
            default: vals[CSR_FULL_DUTY] = 16'($urandom_range(2, 60));
         endcase
         vals[CSR_BREATH_INC] = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                           : 16'($urandom_range(1, 20));
         vals[CSR_ELEM_BLINK]   = pick_span();
         vals[CSR_BREATH_STEP]  = pick_span();
         vals[CSR_FLASH]        = pick_span();
         vals[CSR_DIGIT_GAP]    = pick_span();
         vals[CSR_REPEAT_PAUSE] = pick_span();
         load_settings(vals);

         len = $urandom_range(30, 90);
         step_max = ($urandom_range(0, 7) == 0) ? 70000 : $urandom_range(1, 12);
         if ($urandom_range(0, 3) == 0) tick_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
         else tick_now = $urandom;

         for (int k = 0; k < len; k++) begin
            if (k == 0 || $urandom_range(0, 24) == 0) begin
               // new mode, or a code change in the middle of a sequence
               kind = $urandom_range(0, 9);
               burner = 1'($urandom_range(0, 1));
               element = 1'($urandom_range(0, 1));
               code = 8'd0;
               slot = $urandom_range(0, MAX_SLOTS - 1);
               if (kind < 4) begin
                  if ($urandom_range(0, 3) == 0) code = 8'($urandom_range(1, 25) * 10);
                  else code = 8'($urandom_range(1, 255));
               end else if (kind < 6) begin
                  burner = 1'b1;
                  element = 1'b0;
               end else if (kind < 8) begin
                  burner = 1'b0;
                  element = 1'b1;
               end else if (kind == 8) begin
                  burner = 1'b1;
                  element = 1'b1;
               end else begin
                  burner = 1'b0;
                  element = 1'b0;
               end
            end
            if ($urandom_range(0, 9) == 0) begin
               // noise word: any tick, any flags, sparse random codes
               c.now_ms = $urandom;
               c.burner_on = 1'($urandom_range(0, 1));
               c.element_on = 1'($urandom_range(0, 1));
               for (int i = 0; i < MAX_SLOTS; i++)
                  c.fault[i] = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
               send_call(c);
            end else begin
               tick_now = tick_now + $urandom_range(0, step_max);
               send_mode(tick_now, burner, element, code, slot);
            end
         end
         sent = sent + len;
      end
      wait_writes_drained();
   endtask

   // Response side holds off for a long stretch while words keep coming,
   // so the pipeline fills and request ready drops.
   task automatic test_backpressure();
      reg_set_type vals;
      vals = '{16'd500, 16'd3, 16'd2, 16'd37, 16'd2, 16'd3, 16'd5};
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      load_settings(vals);
      hold_rsp <= 1'b1;
      for (int k = 0; k < 40; k++) begin
         tick_now = tick_now + $urandom_range(0, 3);
         send_mode(tick_now, 1'b0, 1'b0, 8'd123, 2);
      end
      wait_writes_drained();
   endtask

   // ---------------------------------------------------------------------
   // Response ready: random stall bursts, or one long hold on request.
   // ---------------------------------------------------------------------
   initial begin : rsp_ready_driver
      int gap;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            hold_rsp <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else if (rsp_idle_en && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 18);
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Every accepted response word is checked against the oldest expectation.
   always @(posedge clock) begin : write_checker
      wr_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_writes.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected word: written=%0b duty=%0d", $time,
                        rsp_if.duty_written, rsp_if.duty);
         end else begin
            want = expected_writes.pop_front();
            if (rsp_if.duty_written !== want.written) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: duty_written mismatch: expected %0b, got %0b", $time,
                           want.written, rsp_if.duty_written);
            end
            if (rsp_if.duty !== want.duty) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: duty mismatch: expected %0d, got %0d", $time,
                           want.duty, rsp_if.duty);
            end
         end
      end
   end

   // Watchdog on a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.now_ms     = '0;
      req_if.burner_on  = 1'b0;
      req_if.element_on = 1'b0;
      req_if.fault_0    = '0;
      req_if.fault_1    = '0;
      req_if.fault_2    = '0;
      req_if.fault_3    = '0;
      req_if.fault_4    = '0;
      req_if.fault_5    = '0;
      req_if.fault_6    = '0;
      req_if.fault_7    = '0;
      tick_now          = '0;
      led_regs[CSR_FULL_DUTY]    = FULL_DUTY_RST;
      led_regs[CSR_ELEM_BLINK]   = ELEM_BLINK_RST;
      led_regs[CSR_BREATH_STEP]  = BREATH_STEP_RST;
      led_regs[CSR_BREATH_INC]   = BREATH_INC_RST;
      led_regs[CSR_FLASH]        = FLASH_RST;
      led_regs[CSR_DIGIT_GAP]    = DIGIT_GAP_RST;
      led_regs[CSR_REPEAT_PAUSE] = REPEAT_PAUSE_RST;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_corner_settings();
      test_random_sessions(1000, 1'b1);
      test_backpressure();
      test_random_sessions(150, 1'b0);   // closing stretch with no idling

      wait_writes_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
